@@ rtl/tccs_pkg.sv @@
`default_nettype none

package tccs_pkg;

   // Screen geometry: row 0 is the status line, rows 1 to ROWS-1 hold text.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Field widths of the request and response ports.
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 11;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 2 * BYTE_W;

   // Cell store: character in the low byte, attribute in the high byte.
   localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [BYTE_W-1:0] BLANK_ATTR   = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;

   localparam logic [ROW_W-1:0] FIRST_ROW = ROW_W'(1);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

   // Linear addresses used by the scroll and clear sweeps.
   localparam logic [IDX_W-1:0] TEXT_BASE = IDX_W'(COLUMNS);
   localparam logic [IDX_W-1:0] LAST_BASE = IDX_W'((ROWS - 1) * COLUMNS);
   localparam logic [IDX_W-1:0] COPY_END  = IDX_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0] CELL_LIM  = IDX_W'(CELLS);
   localparam logic [IDX_W-1:0] ROW_STEP  = IDX_W'(COLUMNS);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_COPY,
      ST_BLANK,
      ST_READ,
      ST_DONE
   } state_type;

   // Linear cell address of a row and column.
   function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_index = IDX_W'(row) * ROW_STEP + IDX_W'(col);
   endfunction

endpackage

`default_nettype wire

@@ rtl/text_console_cursor_scroll.sv @@
// A printable character, newline or backspace without a scroll, and an unused command,
// are answered in the next cycle; a new request can be taken every cycle while the response is taken.
// A read goes through the registered port of the cell store, then the ST_READ and ST_DONE states.
// A scroll moves the text rows up by one row and blanks the bottom row: one cell moved or blanked per cycle.
// A clear blanks all CELLS cells, one cell blanked per cycle on the single write port.
// After reset a fill pass blanks all CELLS cells of the store; no request is taken meanwhile.
`default_nettype none

module text_console_cursor_scroll
   import tccs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [BYTE_W-1:0] req_char_code,
   input  wire logic [BYTE_W-1:0] req_attr,
   input  wire logic [IDX_W-1:0]  req_read_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [BYTE_W-1:0] rsp_cell_char,
   output logic      [BYTE_W-1:0] rsp_cell_attr,
   output logic      [ROW_W-1:0]  rsp_cursor_row,
   output logic      [COL_W-1:0]  rsp_cursor_col,
   output logic      [IDX_W-1:0]  rsp_cursor_pos,
   output logic                   rsp_scrolled
);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [BYTE_W-1:0] res_char_ff, res_char_in;
   logic [BYTE_W-1:0] res_attr_ff, res_attr_in;
   logic              res_scr_ff, res_scr_in;
   logic              rd_oob_ff, rd_oob_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic [BYTE_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [IDX_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic              out_free;
   logic              accept;
   cmd_type           cmd;

   logic [ROW_W-1:0]  put_row;
   logic [COL_W-1:0]  put_col;
   logic              put_scroll;
   logic              put_we;
   logic [IDX_W-1:0]  put_waddr;
   logic [CELL_W-1:0] put_wdata;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   // Handshake helpers.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   // Cursor movement and cell write for a put request.
   always_comb begin
      logic [IDX_W-1:0] base;
      logic [ROW_W-1:0] row_t;
      base       = cell_index(cur_row_ff, cur_col_ff);
      row_t      = cur_row_ff;
      put_col    = cur_col_ff;
      put_we     = 1'b0;
      put_waddr  = base;
      put_wdata  = {req_attr, req_char_code};
      priority if (req_char_code == CH_NEWLINE) begin
         put_col = '0;
         row_t   = cur_row_ff + ROW_W'(1);
      end else if (req_char_code == CH_BACKSPACE) begin
         if (cur_col_ff != '0) begin
            put_col   = cur_col_ff - COL_W'(1);
            put_we    = 1'b1;
            put_waddr = base - IDX_W'(1);
            put_wdata = BLANK_CELL;
         end else if (cur_row_ff > FIRST_ROW) begin
            row_t   = cur_row_ff - ROW_W'(1);
            put_col = LAST_COL;
         end
      end else begin
         put_we = 1'b1;
         if (cur_col_ff == LAST_COL) begin
            put_col = '0;
            row_t   = cur_row_ff + ROW_W'(1);
         end else begin
            put_col = cur_col_ff + COL_W'(1);
         end
      end
      put_scroll = row_t > LAST_ROW;
      put_row    = put_scroll ? LAST_ROW : row_t;
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (ptr_ff == CELL_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_PUT:   state_in = put_scroll ? ST_COPY : ST_IDLE;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_READ:  state_in = ST_READ;
                  CMD_NOP:   state_in = ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (ptr_ff == CELL_LAST) state_in = ST_DONE;
         end
         ST_COPY: begin
            if (ptr_ff == COPY_END) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (!wr_pend_ff && ptr_ff == CELL_LAST) state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer: store port, pointer, cursor and response registers.
   always_comb begin
      ptr_in       = ptr_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      res_char_in  = res_char_ff;
      res_attr_in  = res_attr_ff;
      res_scr_in   = res_scr_ff;
      rd_oob_in    = rd_oob_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = BLANK_CELL;
      ram_raddr    = req_read_index;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_scr_in   = rsp_scr_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               res_char_in = '0;
               res_attr_in = '0;
               res_scr_in  = 1'b0;
               rd_oob_in   = req_read_index >= CELL_LIM;
               unique case (cmd)
                  CMD_PUT: begin
                     ram_we     = put_we;
                     ram_waddr  = put_waddr;
                     ram_wdata  = put_wdata;
                     cur_row_in = put_row;
                     cur_col_in = put_col;
                     res_scr_in = put_scroll;
                     ptr_in     = TEXT_BASE;
                     if (!put_scroll) begin
                        rsp_valid_in = 1'b1;
                        rsp_char_in  = '0;
                        rsp_attr_in  = '0;
                        rsp_row_in   = put_row;
                        rsp_col_in   = put_col;
                        rsp_pos_in   = cell_index(put_row, put_col);
                        rsp_scr_in   = 1'b0;
                     end
                  end
                  CMD_CLEAR: begin
                     cur_row_in = FIRST_ROW;
                     cur_col_in = '0;
                     ptr_in     = '0;
                  end
                  CMD_READ: begin
                  end
                  CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = '0;
                     rsp_attr_in  = '0;
                     rsp_row_in   = cur_row_ff;
                     rsp_col_in   = cur_col_ff;
                     rsp_pos_in   = cell_index(cur_row_ff, cur_col_ff);
                     rsp_scr_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            // Read the cell one row below; write back the cell read in the previous copy cycle.
            ram_raddr  = ptr_ff + ROW_STEP;
            ram_we     = wr_pend_ff;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            wr_pend_in = 1'b1;
            wr_addr_in = ptr_ff;
            ptr_in     = (ptr_ff == COPY_END) ? LAST_BASE : ptr_ff + IDX_W'(1);
         end
         ST_BLANK: begin
            // The last moved cell goes out first, then the bottom row is blanked.
            ram_we = 1'b1;
            if (wr_pend_ff) begin
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         ST_READ: begin
            res_char_in = rd_oob_ff ? '0 : ram_rdata[BYTE_W-1:0];
            res_attr_in = rd_oob_ff ? '0 : ram_rdata[CELL_W-1:BYTE_W];
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_char_ff;
               rsp_attr_in  = res_attr_ff;
               rsp_row_in   = cur_row_ff;
               rsp_col_in   = cur_col_ff;
               rsp_pos_in   = cell_index(cur_row_ff, cur_col_ff);
               rsp_scr_in   = res_scr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state is reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         cur_row_ff   <= FIRST_ROW;
         cur_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wr_pend_ff   <= wr_pend_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      res_char_ff <= res_char_in;
      res_attr_ff <= res_attr_in;
      res_scr_ff  <= res_scr_in;
      rd_oob_ff   <= rd_oob_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   // Cell store.
   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   // The cursor never leaves the text area.
   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      cur_row_ff >= FIRST_ROW && cur_row_ff <= LAST_ROW && cur_col_ff <= LAST_COL)
      else $error("cursor outside the text area");

   // A pending moved cell exists only right after a copy cycle.
   a_pend_after_copy: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(state_ff) == ST_COPY)
      else $error("pending cell write without a preceding copy cycle");

   // The bottom-row blanking stays inside the last row.
   a_blank_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLANK |-> ptr_ff >= LAST_BASE)
      else $error("blank sweep outside the last row");

   // A response that reports a scroll leaves the cursor on the last row.
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_scr_ff |-> rsp_row_ff == LAST_ROW)
      else $error("scroll reported with cursor off the last row");

   // No request is taken while the store is being swept.
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY || state_ff == ST_CLEAR || state_ff == ST_INIT) |-> !req_ready)
      else $error("request taken during a sweep");

endmodule

`default_nettype wire

@@ rtl/tccs_ram.sv @@
`default_nettype none

module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
